// File: hw/rtl/pmd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package pmd_pkg;

  // Status bit that marks a byte from the auxiliary (mouse) port
  localparam int unsigned AuxBit = 5;
  // Buttons tracked in the packet's first byte
  localparam int unsigned NumButtons = 3;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  // Packet position codes
  typedef enum logic [1:0] {
    POS_BUTTONS = 2'd0,
    POS_DX      = 2'd1,
    POS_DY      = 2'd2
  } pos_t;

  // One completed packet, already classified into pending events
  typedef struct packed {
    logic                  has_move;
    logic signed [7:0]     move_x;
    logic signed [8:0]     move_y;
    logic [NumButtons-1:0] change;
    logic [NumButtons-1:0] press;
  } packet_t;

  // Queue status toward front and back
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } queue_status_t;

endpackage

// File: hw/rtl/pmd_front.sv
// Front end: accepts bytes, assembles packets and classifies their events.
module pmd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            status_byte,
  input  logic [7:0]            data_byte,
  input  pmd_pkg::queue_status_t q_status,
  output logic                  push,
  output pmd_pkg::packet_t      push_packet
);

  pmd_pkg::pos_t                      pos;
  pmd_pkg::pos_t                      pos_next;
  logic [pmd_pkg::NumButtons-1:0]     button_mask;
  logic [7:0]                         slot_buttons;
  logic [7:0]                         slot_dx;
  logic                               take;
  logic                               completes;
  logic [8:0]                         dy_ext;
  logic [pmd_pkg::NumButtons-1:0]     new_mask;

  // Hold input while the queue has no room
  assign in_stall = !q_status.not_full;
  assign take     = in_valid && !in_stall && status_byte[pmd_pkg::AuxBit];
  assign completes = take && (pos == pmd_pkg::POS_DY);

  // Classify the completed packet
  assign new_mask = slot_buttons[pmd_pkg::NumButtons-1:0];
  assign dy_ext   = {data_byte[7], data_byte};
  always_comb begin
    push_packet.has_move = (slot_dx != 8'd0) || (data_byte != 8'd0);
    push_packet.move_x   = slot_dx;
    push_packet.move_y   = 9'd0 - dy_ext;
    push_packet.change   = new_mask ^ button_mask;
    push_packet.press    = new_mask;
  end
  // Drop packets that produce no events
  assign push = completes && (push_packet.has_move || (push_packet.change != '0));

  // Advance packet position
  always_comb begin
    pos_next = pos;
    if (take) begin
      unique case (pos)
        pmd_pkg::POS_BUTTONS: pos_next = pmd_pkg::POS_DX;
        pmd_pkg::POS_DX:      pos_next = pmd_pkg::POS_DY;
        default:              pos_next = pmd_pkg::POS_BUTTONS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= pmd_pkg::POS_BUTTONS;
      button_mask <= '0;
    end else begin
      pos <= pos_next;
      if (completes) button_mask <= new_mask;
    end
  end

  // Packet slots need no reset
  always_ff @(posedge clk) begin
    if (take && (pos == pmd_pkg::POS_BUTTONS)) slot_buttons <= data_byte;
    if (take && (pos == pmd_pkg::POS_DX))      slot_dx      <= data_byte;
  end

endmodule

// File: hw/rtl/pmd_queue.sv
// Small packet queue between front and back ends.
module pmd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pmd_pkg::packet_t       push_packet,
  input  logic                   pop,
  output pmd_pkg::packet_t       head,
  output pmd_pkg::queue_status_t status
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pmd_pkg::packet_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign status.not_full  = (count != FullCnt);
  assign status.not_empty = (count != '0);
  assign head             = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_packet;
  end

endmodule

// File: hw/rtl/pmd_back.sv
// Back end: walks each packet's pending events into the output register.
module pmd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  pmd_pkg::queue_status_t q_status,
  input  pmd_pkg::packet_t       head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             event_kind,
  output logic signed [7:0]      move_x,
  output logic signed [8:0]      move_y,
  output logic [1:0]             button_number,
  output logic                   last_event
);

  logic                           work_valid;
  pmd_pkg::packet_t               work;
  pmd_pkg::packet_t               work_next;
  logic                           advance;
  logic                           emit;
  logic                           emit_last;
  logic [pmd_pkg::NumButtons-1:0] rest;
  logic [pmd_pkg::NumButtons-1:0] low_bit;
  logic [1:0]                     btn_num;
  pmd_pkg::kind_t                 kind;

  // Output register takes a new event when free or being taken
  assign advance = !out_valid || !out_stall;
  assign emit    = advance && work_valid;

  // Pick the next event: move first, then lowest changed button
  assign rest    = work.change & (work.change - 1'b1);
  assign low_bit = work.change & ~rest;
  always_comb begin
    btn_num = 2'd0;
    for (int i = pmd_pkg::NumButtons - 1; i >= 0; i--) begin
      if (low_bit[i]) btn_num = 2'(i + 1);
    end
  end

  always_comb begin
    work_next = work;
    if (work.has_move) begin
      kind               = pmd_pkg::KIND_MOVE;
      work_next.has_move = 1'b0;
      emit_last          = (work.change == '0);
    end else begin
      kind             = ((work.press & low_bit) != '0) ? pmd_pkg::KIND_PRESS
                                                         : pmd_pkg::KIND_RELEASE;
      work_next.change = rest;
      emit_last        = (rest == '0);
    end
  end

  // Load the next packet when the work slot is empty or finishing
  assign pop = q_status.not_empty && (!work_valid || (emit && emit_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop)                    work_valid <= 1'b1;
      else if (emit && emit_last) work_valid <= 1'b0;
      if (advance) out_valid <= work_valid;
    end
  end

  // Work and output payload need no reset
  always_ff @(posedge clk) begin
    if (pop)       work <= head;
    else if (emit) work <= work_next;
    if (emit) begin
      event_kind    <= kind;
      move_x        <= (kind == pmd_pkg::KIND_MOVE) ? work.move_x : 8'sd0;
      move_y        <= (kind == pmd_pkg::KIND_MOVE) ? work.move_y : 9'sd0;
      button_number <= (kind == pmd_pkg::KIND_MOVE) ? 2'd0 : btn_num;
      last_event    <= emit_last;
    end
  end

endmodule

// File: hw/rtl/ps2_mouse_packet_decoder_unit.sv
// Top level of the PS/2 mouse packet decoder.
// A completed packet goes through the queue, the work slot and then the output register.
// Throughput: one byte per cycle while the packet queue has room.
// A packet yields up to four events, so a stalled output fills the QUEUE_DEPTH-entry queue.
// Events leave one per cycle, paced by the back end's walker, while out_stall is low.
// Synchronous reset clears packet position, button mask, queue and output valid.
module ps2_mouse_packet_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic signed [7:0] move_x,
  output logic signed [8:0] move_y,
  output logic [1:0]        button_number,
  output logic              last_event
);

  pmd_pkg::queue_status_t q_status;
  pmd_pkg::packet_t       push_packet;
  pmd_pkg::packet_t       head;
  logic                   push;
  logic                   pop;

  pmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .status_byte (status_byte),
    .data_byte   (data_byte),
    .q_status    (q_status),
    .push        (push),
    .push_packet (push_packet)
  );

  pmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .pop         (pop),
    .head        (head),
    .status      (q_status)
  );

  pmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .move_x        (move_x),
    .move_y        (move_y),
    .button_number (button_number),
    .last_event    (last_event)
  );

endmodule
